[sv/alu8f_pkg.sv]
// ----------------------------------------------------------------------------
// alu8f_pkg
// Types and codes shared by the eight-bit ALU and its core.
// ----------------------------------------------------------------------------
`default_nettype none

package alu8f_pkg;

	// Operation codes
	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_ADC = 4'd1,
		OP_SUB = 4'd2,
		OP_SBC = 4'd3,
		OP_AND = 4'd4,
		OP_XOR = 4'd5,
		OP_OR  = 4'd6,
		OP_CP  = 4'd7,
		OP_INC = 4'd8,
		OP_DEC = 4'd9
	} alu8f_op_t;

	// Flag byte bit positions
	localparam int unsigned FLAG_S  = 7;
	localparam int unsigned FLAG_Z  = 6;
	localparam int unsigned FLAG_B5 = 5;
	localparam int unsigned FLAG_H  = 4;
	localparam int unsigned FLAG_B3 = 3;
	localparam int unsigned FLAG_PV = 2;
	localparam int unsigned FLAG_N  = 1;
	localparam int unsigned FLAG_C  = 0;

	// Flags that INC and DEC pass through: C and the two undocumented bits
	localparam logic [7:0] KEEP_MASK = 8'h29;

	// One operation
	typedef struct packed {
		logic [3:0] opcode;
		logic [7:0] acc_in;
		logic [7:0] operand;
		logic [7:0] flags_in;
	} alu8f_req_t;

	// One result
	typedef struct packed {
		logic [7:0] result;
		logic       write_back;
		logic [7:0] flags_out;
	} alu8f_rsp_t;

endpackage

`default_nettype wire

[sv/alu8f_core.sv]
// ----------------------------------------------------------------------------
// alu8f_core
// Combinational datapath: result, write-back and new flag byte for one operation.
// ----------------------------------------------------------------------------
`default_nettype none

module alu8f_core
	import alu8f_pkg::*;
(
	input  wire alu8f_req_t req,
	output alu8f_rsp_t      rsp
);

	logic       cin;
	logic [8:0] add_sum;
	logic [4:0] add_half;
	logic [8:0] sub_diff;
	logic [4:0] sub_half;
	logic [7:0] a;
	logic [7:0] v;
	logic [7:0] inc_r;
	logic [7:0] dec_r;
	logic [7:0] keep;

	assign a    = req.acc_in;
	assign v    = req.operand;
	assign keep = req.flags_in & KEEP_MASK;

	// Carry in only for ADC and SBC
	assign cin = ((req.opcode == OP_ADC) || (req.opcode == OP_SBC)) ? req.flags_in[FLAG_C]
		: 1'b0;

	// Shared adder and subtractor, nine bits for carry / borrow out
	assign add_sum  = {1'b0, a} + {1'b0, v} + {8'd0, cin};
	assign add_half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
	assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, cin};
	assign sub_half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};

	assign inc_r = v + 8'd1;
	assign dec_r = v - 8'd1;

	// Select result and build flags
	always_comb begin
		rsp.result     = a;
		rsp.write_back = 1'b0;
		rsp.flags_out  = req.flags_in;
		case (req.opcode)
			OP_ADD, OP_ADC: begin
				rsp.result                = add_sum[7:0];
				rsp.write_back            = 1'b1;
				rsp.flags_out             = 8'h00;
				rsp.flags_out[FLAG_S]     = add_sum[7];
				rsp.flags_out[FLAG_Z]     = (add_sum[7:0] == 8'h00);
				rsp.flags_out[FLAG_H]     = add_half[4];
				rsp.flags_out[FLAG_PV]    = (a[7] ^ add_sum[7]) & (v[7] ^ add_sum[7]);
				rsp.flags_out[FLAG_C]     = add_sum[8];
			end
			OP_SUB, OP_SBC, OP_CP: begin
				rsp.result                = sub_diff[7:0];
				rsp.write_back            = (req.opcode != OP_CP);
				rsp.flags_out             = 8'h00;
				rsp.flags_out[FLAG_S]     = sub_diff[7];
				rsp.flags_out[FLAG_Z]     = (sub_diff[7:0] == 8'h00);
				rsp.flags_out[FLAG_H]     = sub_half[4];
				rsp.flags_out[FLAG_PV]    = (a[7] ^ v[7]) & (a[7] ^ sub_diff[7]);
				rsp.flags_out[FLAG_N]     = 1'b1;
				rsp.flags_out[FLAG_C]     = sub_diff[8];
			end
			OP_AND, OP_XOR, OP_OR: begin
				if (req.opcode == OP_AND) begin
					rsp.result = a & v;
				end else if (req.opcode == OP_XOR) begin
					rsp.result = a ^ v;
				end else begin
					rsp.result = a | v;
				end
				rsp.write_back            = 1'b1;
				rsp.flags_out             = 8'h00;
				rsp.flags_out[FLAG_S]     = rsp.result[7];
				rsp.flags_out[FLAG_Z]     = (rsp.result == 8'h00);
				rsp.flags_out[FLAG_H]     = (req.opcode == OP_AND);
				rsp.flags_out[FLAG_PV]    = ~^rsp.result;
			end
			OP_INC: begin
				rsp.result                = inc_r;
				rsp.write_back            = 1'b1;
				rsp.flags_out             = keep;
				rsp.flags_out[FLAG_S]     = inc_r[7];
				rsp.flags_out[FLAG_Z]     = (inc_r == 8'h00);
				rsp.flags_out[FLAG_H]     = (v[3:0] == 4'hF);
				rsp.flags_out[FLAG_PV]    = (v == 8'h7F);
			end
			OP_DEC: begin
				rsp.result                = dec_r;
				rsp.write_back            = 1'b1;
				rsp.flags_out             = keep;
				rsp.flags_out[FLAG_S]     = dec_r[7];
				rsp.flags_out[FLAG_Z]     = (dec_r == 8'h00);
				rsp.flags_out[FLAG_H]     = (v[3:0] == 4'h0);
				rsp.flags_out[FLAG_PV]    = (v == 8'h80);
				rsp.flags_out[FLAG_N]     = 1'b1;
			end
			default: begin
				// undefined opcodes: pass accumulator and flags, no write-back
				rsp.result     = a;
				rsp.write_back = 1'b0;
				rsp.flags_out  = req.flags_in;
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/eight_bit_alu_with_flags_top.sv]
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_top
// Eight-bit accumulator ALU with sign/zero/half/parity-overflow/subtract/carry flags.
// ----------------------------------------------------------------------------
// Issue an operation by raising start with the request on the same cycle; busy is
// always low, so a new operation transfers on every clock. The answer passes
// through the input register, then the result register, to response, marked by done
// for exactly one cycle. There is no back-pressure: the receiver must take each
// response in the cycle done is high. The block keeps no state between operations.
`default_nettype none

module eight_bit_alu_with_flags_top
	import alu8f_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  wire alu8f_req_t request,
	output logic            done,
	output alu8f_rsp_t      response
);

	logic       valid_s1;
	alu8f_req_t req_s1;
	logic       valid_s2;
	alu8f_rsp_t rsp_s2;
	alu8f_rsp_t core_rsp;

	// Never stalls
	assign busy = 1'b0;

	// Input and result stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			req_s1 <= request;
		end
	end

	alu8f_core u_core (
		.req (req_s1),
		.rsp (core_rsp)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_s2 <= core_rsp;
		end
	end

	assign done     = valid_s2;
	assign response = rsp_s2;

endmodule

`default_nettype wire

[test/alu8f_flag_checker.sv]
// ----------------------------------------------------------------------------
// alu8f_flag_checker
// Watches the ALU operation and result channels. Predicts each result and its
// flag byte from the accepted operation, then compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module alu8f_flag_checker
	import alu8f_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire                busy,
	input  wire alu8f_req_t    request,
	input  wire                done,
	input  wire alu8f_rsp_t    response,
	output int unsigned        fail_count,
	output int unsigned        outstanding,
	output int unsigned        checked
);

	// One expected result together with the operation that caused it
	typedef struct {
		alu8f_req_t req;
		alu8f_rsp_t rsp;
	} alu_expect_t;

	alu_expect_t expected_rsp_q[$];

	// Result and flag byte that an operation must produce
	function automatic alu8f_rsp_t predict_alu(input alu8f_req_t req);
		alu8f_rsp_t rsp;
		logic [7:0] a;
		logic [7:0] v;
		logic [7:0] r;
		logic [7:0] f;
		logic [8:0] wide;
		logic [4:0] nib;
		logic       cin;
		a    = req.acc_in;
		v    = req.operand;
		r    = a;
		f    = req.flags_in;
		cin  = 1'b0;
		rsp.write_back = 1'b1;
		case (req.opcode)
			OP_ADD, OP_ADC: begin
				if (req.opcode == OP_ADC)
					cin = req.flags_in[FLAG_C];
				wide = {1'b0, a} + {1'b0, v} + {8'd0, cin};
				nib  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
				r    = wide[7:0];
				f    = '0;
				f[FLAG_H]  = nib[4];
				f[FLAG_C]  = wide[8];
				f[FLAG_PV] = (a[7] ^ r[7]) & (v[7] ^ r[7]);
			end
			OP_SUB, OP_SBC, OP_CP: begin
				if (req.opcode == OP_SBC)
					cin = req.flags_in[FLAG_C];
				// borrow shows up in the extra top bit
				wide = {1'b0, a} - {1'b0, v} - {8'd0, cin};
				nib  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
				r    = wide[7:0];
				f    = '0;
				f[FLAG_N]  = 1'b1;
				f[FLAG_H]  = nib[4];
				f[FLAG_C]  = wide[8];
				// overflow taken with the plain operand, also for SBC
				f[FLAG_PV] = (a[7] ^ v[7]) & (a[7] ^ r[7]);
				if (req.opcode == OP_CP)
					rsp.write_back = 1'b0;
			end
			OP_AND, OP_XOR, OP_OR: begin
				case (req.opcode)
					OP_AND:  r = a & v;
					OP_XOR:  r = a ^ v;
					default: r = a | v;
				endcase
				f = '0;
				f[FLAG_H]  = (req.opcode == OP_AND);
				f[FLAG_PV] = ~^r;
			end
			OP_INC: begin
				r = v + 8'd1;
				f = req.flags_in & KEEP_MASK;
				f[FLAG_H]  = (v[3:0] == 4'hF);
				f[FLAG_PV] = (v == 8'h7F);
			end
			OP_DEC: begin
				r = v - 8'd1;
				f = req.flags_in & KEEP_MASK;
				f[FLAG_N]  = 1'b1;
				f[FLAG_H]  = (v[3:0] == 4'h0);
				f[FLAG_PV] = (v == 8'h80);
			end
			default: begin
				// codes past DEC leave everything as it was
				rsp.write_back = 1'b0;
			end
		endcase
		if (req.opcode <= OP_DEC) begin
			f[FLAG_S] = r[7];
			f[FLAG_Z] = (r == 8'h00);
		end
		rsp.result    = r;
		rsp.flags_out = f;
		return rsp;
	endfunction

	// One line per mismatch, counted
	task automatic report_mismatch(input string msg);
		$display("%0t ERROR %s", $time, msg);
		fail_count++;
	endtask

	// Queue a prediction on each operation transfer, check each result transfer
	always @(posedge clk or negedge arst_n) begin
		alu_expect_t exp_item;
		alu_expect_t new_item;
		if (!arst_n) begin
			expected_rsp_q.delete();
			fail_count  <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch($sformatf("result %h with no operation pending",
						response));
				end else begin
					exp_item = expected_rsp_q.pop_front();
					checked <= checked + 1;
					if (response.result !== exp_item.rsp.result)
						report_mismatch($sformatf("op %0d a=%h v=%h f=%h: result %h, want %h",
							exp_item.req.opcode, exp_item.req.acc_in, exp_item.req.operand,
							exp_item.req.flags_in, response.result, exp_item.rsp.result));
					if (response.write_back !== exp_item.rsp.write_back)
						report_mismatch($sformatf("op %0d a=%h v=%h: write_back %b, want %b",
							exp_item.req.opcode, exp_item.req.acc_in, exp_item.req.operand,
							response.write_back, exp_item.rsp.write_back));
					if (response.flags_out !== exp_item.rsp.flags_out)
						report_mismatch($sformatf("op %0d a=%h v=%h f=%h: flags %h, want %h",
							exp_item.req.opcode, exp_item.req.acc_in, exp_item.req.operand,
							exp_item.req.flags_in, response.flags_out,
							exp_item.rsp.flags_out));
				end
			end
			if (start && !busy) begin
				new_item.req = request;
				new_item.rsp = predict_alu(request);
				expected_rsp_q.push_back(new_item);
			end
			outstanding <= expected_rsp_q.size();
		end
	end

endmodule

[test/tb_eight_bit_alu_with_flags_top.sv]
// ----------------------------------------------------------------------------
// tb_eight_bit_alu_with_flags_top
// Drives flag corner cases of every operation, then random operations in bursts
// with random gaps; a checker beside the ALU predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_eight_bit_alu_with_flags_top;
	import alu8f_pkg::*;

	// Codes past DEC that the ALU must pass through untouched
	localparam logic [3:0] OP_SPARE_LO = 4'd10;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;
	localparam int unsigned RANDOM_OPS = 1000;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	alu8f_req_t request;
	logic       done;
	alu8f_rsp_t response;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned checked;
	int unsigned directed_ops;
	int unsigned random_ops;

	eight_bit_alu_with_flags_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response)
	);

	alu8f_flag_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.done        (done),
		.response    (response),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#2ms;
		$display("timeout with %0d results outstanding", outstanding);
		$display("tb_eight_bit_alu_with_flags_top: FAIL");
		$finish;
	end

	// Present one operation and hold it until it transfers
	task automatic send_op(input logic [3:0] op, input logic [7:0] a,
			input logic [7:0] v, input logic [7:0] f);
		start   <= 1'b1;
		request <= '{opcode: op, acc_in: a, operand: v, flags_in: f};
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start for a number of cycles, with junk on the request bus
	task automatic pause_ops(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) begin
			request <= alu8f_req_t'($urandom);
			@(posedge clk);
		end
	endtask

	// Random byte, leaning on the values where flags flip
	function automatic logic [7:0] pick_byte();
		logic [7:0] corner [7];
		corner = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'hFF};
		if ($urandom_range(3) == 0)
			return corner[$urandom_range(6)];
		return 8'($urandom);
	endfunction

	// Stimulus
	initial begin
		int unsigned burst;
		logic [3:0]  op;
		arst_n       = 1'b0;
		start        = 1'b0;
		request      = '0;
		directed_ops = 0;
		random_ops   = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Flag corner cases, one per line
		send_op(OP_ADD, 8'h7F, 8'h01, 8'h00);     // signed overflow and half carry
		send_op(OP_ADD, 8'hFF, 8'h01, 8'hFF);     // carry out, zero
		send_op(OP_ADD, 8'h00, 8'h00, 8'hFF);     // zero, input carry ignored
		send_op(OP_ADC, 8'hFF, 8'h00, 8'h01);     // carry in wraps to zero
		send_op(OP_ADC, 8'h0F, 8'h00, 8'h01);     // carry in reaches bit 4
		send_op(OP_SUB, 8'h80, 8'h01, 8'h00);     // signed overflow, half borrow
		send_op(OP_SUB, 8'h00, 8'h01, 8'h00);     // borrow, negative
		send_op(OP_SBC, 8'h00, 8'h00, 8'h01);     // borrow from carry alone
		send_op(OP_SBC, 8'h80, 8'h7F, 8'h01);     // overflow on plain operand
		send_op(OP_SBC, 8'hFF, 8'hFF, 8'h00);     // zero without borrow
		send_op(OP_AND, 8'hFF, 8'hFF, 8'h00);     // even parity, negative
		send_op(OP_AND, 8'hF0, 8'h0F, 8'hFF);     // zero, half set
		send_op(OP_XOR, 8'hAA, 8'h55, 8'hFF);     // all ones
		send_op(OP_XOR, 8'h01, 8'h00, 8'h00);     // odd parity
		send_op(OP_OR,  8'h00, 8'h00, 8'hFF);     // zero, undocumented bits cleared
		send_op(OP_CP,  8'h10, 8'h10, 8'h00);     // equal, no write-back
		send_op(OP_CP,  8'h00, 8'hFF, 8'h00);     // less than
		send_op(OP_INC, 8'h00, 8'h7F, 8'h00);     // overflow to negative
		send_op(OP_INC, 8'h55, 8'hFF, 8'h29);     // wrap to zero, kept bits set
		send_op(OP_INC, 8'h00, 8'h0F, 8'hD6);     // half carry, kept bits clear
		send_op(OP_DEC, 8'h00, 8'h80, 8'h00);     // overflow to positive
		send_op(OP_DEC, 8'h00, 8'h00, 8'hFF);     // wrap, half borrow
		send_op(OP_DEC, 8'hFF, 8'h01, 8'h01);     // to zero, carry kept
		send_op(OP_SPARE_LO, 8'h3C, 8'hC3, 8'hA5);
		send_op(OP_SPARE_HI, 8'hC3, 8'h3C, 8'h5A);
		directed_ops = 25;
		pause_ops(3);

		// Random operations in bursts
		while (random_ops < RANDOM_OPS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				if ($urandom_range(9) == 0)
					op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
				else
					op = 4'($urandom_range(OP_DEC));
				send_op(op, pick_byte(), pick_byte(), 8'($urandom));
				random_ops++;
			end
			// back-to-back bursts now and then
			if ($urandom_range(3) != 0)
				pause_ops($urandom_range(1, 6));
		end
		pause_ops(1);

		// Drain, then wait on for stray results
		while (outstanding != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("ran %0d directed and %0d random operations, all ten opcodes plus spares",
			directed_ops, random_ops);
		$display("checked %0d results, %0d mismatches", checked, fail_count);
		if (fail_count == 0)
			$display("tb_eight_bit_alu_with_flags_top: PASS");
		else
			$display("tb_eight_bit_alu_with_flags_top: FAIL");
		$finish;
	end

endmodule
